@@ rtl/core/utf8_to_utf16_decoder_macros.svh @@
// Assertion macros for the UTF-8 to UTF-16 decoder checker.
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define U8U16_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define U8U16_ASSERT_IMP(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define U8U16_ASSERT_NXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/u8u16dec_pkg.sv @@
// Package: shared types and constants of the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps
package u8u16dec_pkg;

    // Result queue depth, a power of two of at least four.
    localparam int OUTQ_DEPTH = 4;

    // Register indexes and reset value.
    localparam logic REG_OS_LEVEL = 1'b0;
    localparam logic [1:0] OS_LEVEL_RESET = 2'd2;

    // One result item.
    typedef struct packed {
        logic        last;
        logic        error;
        logic [15:0] code_unit;
    } unit_t;

    // Results caused by one accepted byte: zero, one or two units.
    typedef struct packed {
        logic [1:0] count;
        unit_t      u0;
        unit_t      u1;
    } dec_res_t;

endpackage

@@ rtl/core/utf8_to_utf16_decoder.sv @@
// Units are queued as their byte is accepted and leave one a cycle while m_tready is high.
// Throughput: one byte per cycle; a four-byte sequence can yield two units.
// The input side stalls only while the result queue lacks room for two units.
// Reset (rst_n low, asynchronous) clears the sequence state, the error flag and the queue,
// and sets os_level to 2 (no substitution).
`timescale 1ns / 1ps
module utf8_to_utf16_decoder
#(
    parameter int OUTQ_DEPTH = u8u16dec_pkg::OUTQ_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Byte input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte

    // Code unit output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] code_unit
    output logic [0:0]  m_tuser,    // [0] error
    output logic        m_tlast,    // terminator result

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]             os_level_reg;
    logic [1:0]             os_level_next;
    logic                   in_accept;
    logic                   room;
    u8u16dec_pkg::dec_res_t res;
    u8u16dec_pkg::unit_t    out_unit;

    // Configuration: one register, word aligned; only paddr[2] selects it.
    assign pready = 1'b1;

    always_comb
    begin
        os_level_next = os_level_reg;
        if (psel && penable && pwrite && paddr[2] == u8u16dec_pkg::REG_OS_LEVEL)
            os_level_next = pwdata[1:0];
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == u8u16dec_pkg::REG_OS_LEVEL)
            prdata = {30'd0, os_level_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            os_level_reg <= u8u16dec_pkg::OS_LEVEL_RESET;
        else
            os_level_reg <= os_level_next;
    end

    // Accept a byte whenever the queue can absorb the worst case of two units.
    assign s_tready  = room;
    assign in_accept = s_tvalid & s_tready;

    // Decode the byte against the pending sequence and advance the state.
    u8u16dec_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (s_tdata),
        .os_level  (os_level_reg),
        .res       (res)
    );

    // Hold results until the sink takes them, one item per cycle.
    u8u16dec_outq
    #(
        .DEPTH (OUTQ_DEPTH)
    )
    u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_unit  (out_unit)
    );

    assign m_tdata    = out_unit.code_unit;
    assign m_tuser[0] = out_unit.error;
    assign m_tlast    = out_unit.last;

endmodule

@@ rtl/core/u8u16dec_core.sv @@
// Decoder core: sequence state and the per-byte decode into code units.
`timescale 1ns / 1ps
module u8u16dec_core
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              data_byte,
    input  logic [1:0]              os_level,
    output u8u16dec_pkg::dec_res_t  res
);

    localparam logic [1:0]  OS_PRE_WIN8  = 2'd0;
    localparam logic [1:0]  OS_WIN10     = 2'd2;
    localparam logic [15:0] SPACE        = 16'h0020;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] PLANE1_BASE  = 21'h010000;

    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [2:0]  seq_length_reg, seq_length_next;
    logic [20:0] partial_code_reg, partial_code_next;
    logic        bad_string_reg, bad_string_next;

    logic [20:0] shifted;
    logic [1:0]  left_dec;
    logic [20:0] cp4;
    logic [20:0] cp4_off;

    function automatic logic [15:0] subst16(input logic [15:0] c, input logic [1:0] os);
        logic [15:0] r;
        r = c;
        if (os == OS_PRE_WIN8)
        begin
            if (c == 16'h2705)
                r = 16'h2714;
            else if (c >= 16'h2667 && c <= 16'h2775)
                r = SPACE;
        end
        return r;
    endfunction

    function automatic logic [20:0] subst32(input logic [20:0] c, input logic [1:0] os);
        logic [20:0] r;
        r = c;
        if (os < OS_WIN10)
        begin
            if (c == 21'h1F388 || c == 21'h1F534 || c == 21'h1F535)
                r = 21'h025CF;
            else if (c >= 21'h1F600 && c <= 21'h1F64F)
                r = 21'h0263A;
            else if (c >= 21'h1F300)
                r = {5'd0, SPACE};
        end
        return r;
    endfunction

    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        seq_length_next   = seq_length_reg;
        partial_code_next = partial_code_reg;
        bad_string_next   = bad_string_reg;
        res               = '0;

        shifted  = {partial_code_reg[14:0], data_byte[5:0]};
        left_dec = bytes_left_reg - 2'd1;
        cp4      = subst32(shifted, os_level);
        cp4_off  = cp4 - PLANE1_BASE;

        if (data_byte == 8'd0)
        begin
            // Terminator: report and clear the string state.
            res.count        = 2'd1;
            res.u0.last      = 1'b1;
            res.u0.error     = bad_string_reg | (bytes_left_reg != 2'd0);
            res.u0.code_unit = 16'd0;
            bytes_left_next   = 2'd0;
            seq_length_next   = 3'd0;
            partial_code_next = 21'd0;
            bad_string_next   = 1'b0;
        end
        else if (bad_string_reg)
        begin
            // Drop everything up to the terminator.
        end
        else if (bytes_left_reg != 2'd0)
        begin
            if (data_byte[7:6] != 2'b10)
            begin
                bad_string_next   = 1'b1;
                bytes_left_next   = 2'd0;
                seq_length_next   = 3'd0;
                partial_code_next = 21'd0;
            end
            else if (left_dec != 2'd0)
            begin
                partial_code_next = shifted;
                bytes_left_next   = left_dec;
            end
            else
            begin
                partial_code_next = 21'd0;
                bytes_left_next   = 2'd0;
                seq_length_next   = 3'd0;
                case (seq_length_reg)
                    3'd2:
                    begin
                        res.count        = 2'd1;
                        res.u0.code_unit = shifted[15:0];
                    end
                    3'd3:
                    begin
                        res.count        = 2'd1;
                        res.u0.code_unit = subst16(shifted[15:0], os_level);
                    end
                    default:
                    begin
                        if (cp4[20:16] == 5'd0)
                        begin
                            res.count        = 2'd1;
                            res.u0.code_unit = cp4[15:0];
                        end
                        else
                        begin
                            res.count        = 2'd2;
                            res.u0.code_unit = SURR_HI_BASE | {6'd0, cp4_off[19:10]};
                            res.u1.code_unit = SURR_LO_BASE | {6'd0, cp4[9:0]};
                        end
                    end
                endcase
            end
        end
        else if (data_byte[7] == 1'b0)
        begin
            res.count        = 2'd1;
            res.u0.code_unit = {8'd0, data_byte};
        end
        else if (data_byte[7:5] == 3'b110)
        begin
            partial_code_next = {16'd0, data_byte[4:0]};
            seq_length_next   = 3'd2;
            bytes_left_next   = 2'd1;
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            partial_code_next = {17'd0, data_byte[3:0]};
            seq_length_next   = 3'd3;
            bytes_left_next   = 2'd2;
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            partial_code_next = {18'd0, data_byte[2:0]};
            seq_length_next   = 3'd4;
            bytes_left_next   = 2'd3;
        end
        else
        begin
            bad_string_next = 1'b1;
        end

        if (!accept)
        begin
            res.count         = 2'd0;
            bytes_left_next   = bytes_left_reg;
            seq_length_next   = seq_length_reg;
            partial_code_next = partial_code_reg;
            bad_string_next   = bad_string_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg   <= 2'd0;
            seq_length_reg   <= 3'd0;
            partial_code_reg <= 21'd0;
            bad_string_reg   <= 1'b0;
        end
        else
        begin
            bytes_left_reg   <= bytes_left_next;
            seq_length_reg   <= seq_length_next;
            partial_code_reg <= partial_code_next;
            bad_string_reg   <= bad_string_next;
        end
    end

endmodule

@@ rtl/core/u8u16dec_outq.sv @@
// Result queue: takes up to two units per cycle, hands out one per cycle while out_ready is high.
`timescale 1ns / 1ps
module u8u16dec_outq
#(
    parameter int DEPTH = u8u16dec_pkg::OUTQ_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  u8u16dec_pkg::dec_res_t  res,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output u8u16dec_pkg::unit_t     out_unit
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    u8u16dec_pkg::unit_t mem_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;

    assign room      = cnt_reg <= CW'(DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_unit  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(res.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        cnt_next    = cnt_reg + CW'(res.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (res.count != 2'd0)
            mem_reg[wr_ptr_reg] <= res.u0;
        if (res.count == 2'd2)
            mem_reg[wr_ptr_reg + PW'(1)] <= res.u1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/core/u8u16dec_checker.sv @@
// Checker on the decoder's output ports, bound to the top level.
`timescale 1ns / 1ps
`include "utf8_to_utf16_decoder_macros.svh"
module u8u16dec_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    logic        out_stall;
    logic [17:0] out_item;

    assign out_stall = m_tvalid && !m_tready;
    assign out_item  = {m_tlast, m_tuser, m_tdata};

    `U8U16_ASSERT_NXT(a_hold, out_stall, m_tvalid && $stable(out_item), "stalled item changed")
    `U8U16_ASSERT_IMP(a_err_last, m_tvalid && m_tuser[0], m_tlast, "error off the terminator")
    `U8U16_ASSERT_IMP(a_term_zero, m_tvalid && m_tlast, m_tdata == '0, "nonzero terminator unit")
    `U8U16_ASSERT(a_valid_known, !$isunknown(m_tvalid), "output valid unknown")

endmodule

bind utf8_to_utf16_decoder u8u16dec_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/sv/utf8_to_utf16_decoder_tb.sv @@
// Self-checking testbench for the UTF-8 to UTF-16 decoder: stream stimulus, prediction, scoring.
`timescale 1ns / 1ps
module utf8_to_utf16_decoder_tb;

    // OS levels as the configuration register encodes them
    localparam logic [1:0] OS_PRE_WIN8    = 2'd0;
    localparam logic [1:0] OS_WIN8        = 2'd1;
    localparam logic [1:0] OS_WIN10       = 2'd2;
    localparam logic [1:0] OS_WIN10_ALIAS = 2'd3;  // behaves as Win10, no substitution

    // Byte address of the OS level register on the configuration port
    localparam logic [2:0] OS_ADDR = 3'(4 * u8u16dec_pkg::REG_OS_LEVEL);

    // Code points involved in substitution and surrogate building
    localparam logic [15:0] CHECK_HEAVY_IN  = 16'h2705;
    localparam logic [15:0] CHECK_HEAVY_OUT = 16'h2714;
    localparam logic [15:0] SYM_LO          = 16'h2667;
    localparam logic [15:0] SYM_HI          = 16'h2775;
    localparam logic [15:0] SPACE           = 16'h0020;
    localparam logic [15:0] BLACK_CIRCLE    = 16'h25CF;
    localparam logic [15:0] SMILEY          = 16'h263A;
    localparam logic [20:0] BALLOON         = 21'h1F388;
    localparam logic [20:0] RED_CIRCLE      = 21'h1F534;
    localparam logic [20:0] BLUE_CIRCLE     = 21'h1F535;
    localparam logic [20:0] EMOJI_LO        = 21'h1F600;
    localparam logic [20:0] EMOJI_HI        = 21'h1F64F;
    localparam logic [20:0] PICTO_LO        = 21'h1F300;
    localparam logic [20:0] PLANE1          = 21'h010000;
    localparam logic [15:0] SURR_HI         = 16'hD800;
    localparam logic [15:0] SURR_LO         = 16'hDC00;

    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 290;     // random bytes per configuration phase
    localparam int SETTLE      = 8;       // cycles after the last result before touching config
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int MAX_CYCLES  = 400000;  // run limit

    // Tracks decoder state and holds the code units still to come out
    class utf16_scoreboard;
        u8u16dec_pkg::unit_t expected_units[$];
        logic [1:0]  os_level;
        logic [1:0]  cont_left;
        logic [2:0]  seq_len;
        logic [20:0] code_acc;
        logic        string_bad;
        int          fails;
        int          units_seen;
        int          strings_done;
        int          strings_bad;

        function new();
            os_level     = u8u16dec_pkg::OS_LEVEL_RESET;
            fails        = 0;
            units_seen   = 0;
            strings_done = 0;
            strings_bad  = 0;
            clear_string();
        endfunction

        function void clear_string();
            cont_left  = 2'd0;
            seq_len    = 3'd0;
            code_acc   = '0;
            string_bad = 1'b0;
        endfunction

        function void push_unit(logic [15:0] cu, logic err, logic fin);
            expected_units.push_back({fin, err, cu});
        endfunction

        function int pending();
            return expected_units.size();
        endfunction

        // Advance the decoder state by one accepted byte and queue what it yields
        function void note_byte(logic [7:0] b);
            logic [20:0] cp;
            logic [20:0] off;
            if (b == 8'h00)
            begin
                push_unit(16'h0000, string_bad || (cont_left != 2'd0), 1'b1);
                clear_string();
                return;
            end
            if (string_bad)
                return;
            if (cont_left != 2'd0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    // drop the sequence; the offending byte is not decoded again
                    string_bad = 1'b1;
                    cont_left  = 2'd0;
                    seq_len    = 3'd0;
                    code_acc   = '0;
                    return;
                end
                code_acc  = {code_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left != 2'd0)
                    return;
                cp       = code_acc;
                code_acc = '0;
                if (seq_len == 3'd2)
                    push_unit(cp[15:0], 1'b0, 1'b0);
                else if (seq_len == 3'd3)
                begin
                    if (os_level == OS_PRE_WIN8 && cp[15:0] == CHECK_HEAVY_IN)
                        cp = {5'd0, CHECK_HEAVY_OUT};
                    else if (os_level == OS_PRE_WIN8 &&
                             cp[15:0] >= SYM_LO && cp[15:0] <= SYM_HI)
                        cp = {5'd0, SPACE};
                    push_unit(cp[15:0], 1'b0, 1'b0);
                end
                else
                begin
                    if (os_level < OS_WIN10)
                    begin
                        if (cp == BALLOON || cp == RED_CIRCLE || cp == BLUE_CIRCLE)
                            cp = {5'd0, BLACK_CIRCLE};
                        else if (cp >= EMOJI_LO && cp <= EMOJI_HI)
                            cp = {5'd0, SMILEY};
                        else if (cp >= PICTO_LO)
                            cp = {5'd0, SPACE};
                    end
                    if (cp <= 21'h00FFFF)
                        push_unit(cp[15:0], 1'b0, 1'b0);
                    else
                    begin
                        // offset bits above bit 19 fall away, so huge values wrap
                        off = cp - PLANE1;
                        push_unit(SURR_HI | {6'd0, off[19:10]}, 1'b0, 1'b0);
                        push_unit(SURR_LO | {6'd0, cp[9:0]}, 1'b0, 1'b0);
                    end
                end
                seq_len = 3'd0;
                return;
            end
            if (b[7] == 1'b0)
                push_unit({8'd0, b}, 1'b0, 1'b0);
            else if (b[7:5] == 3'b110)
            begin
                code_acc  = {16'd0, b[4:0]};
                seq_len   = 3'd2;
                cont_left = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                code_acc  = {17'd0, b[3:0]};
                seq_len   = 3'd3;
                cont_left = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                code_acc  = {18'd0, b[2:0]};
                seq_len   = 3'd4;
                cont_left = 2'd3;
            end
            else
                string_bad = 1'b1;
        endfunction

        task report(string what);
            fails++;
            // keep the log short when things go badly wrong
            if (fails <= 40)
                $display("ERROR: %s", what);
        endtask

        task check_unit(u8u16dec_pkg::unit_t got);
            u8u16dec_pkg::unit_t want;
            units_seen++;
            if (expected_units.size() == 0)
            begin
                report($sformatf("unexpected unit %h error %b last %b",
                                 got.code_unit, got.error, got.last));
                return;
            end
            want = expected_units.pop_front();
            if (got.code_unit !== want.code_unit)
                report($sformatf("unit %0d: code_unit %h, want %h",
                                 units_seen, got.code_unit, want.code_unit));
            if (got.error !== want.error)
                report($sformatf("unit %0d: error %b, want %b",
                                 units_seen, got.error, want.error));
            if (got.last !== want.last)
                report($sformatf("unit %0d: last %b, want %b", units_seen, got.last, want.last));
            if (want.last)
            begin
                strings_done++;
                if (want.error)
                    strings_bad++;
            end
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [15:0] code_unit
    logic [0:0]  m_tuser;            // [0] error
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    utf16_scoreboard sb;

    logic tx_gaps      = 1'b1;
    logic rx_gaps      = 1'b1;
    int   hold_req_cnt = 0;   // bumped by the stimulus to ask for a long hold-off
    int   hold_seen    = 0;
    int   rx_hold_left = 0;
    int   cycles       = 0;
    int   bytes_sent   = 0;
    int   phase_bytes  = 0;

    // Directed strings: extremes of each sequence length, a surrogate pair, a value above
    // the Unicode range, an overlong four-byte form, a bad continuation byte that is not
    // decoded again, and a truncated sequence
    logic [7:0] directed_bytes[25] = '{
        8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
        8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hF0, 8'h80, 8'h80, 8'h80, 8'hE2, 8'h41, 8'h00,
        8'hF0, 8'h9F, 8'h00
    };

    // Settings walked through, extremes included
    logic [1:0] phase_os[PHASES] = '{
        OS_PRE_WIN8, OS_WIN8, OS_WIN10, OS_WIN10_ALIAS, OS_PRE_WIN8, OS_WIN8
    };

    utf8_to_utf16_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= MAX_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d units still due", cycles, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: score every accepted unit, then pick next cycle's tready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_unit({m_tlast, m_tuser[0], m_tdata});
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req_cnt != hold_seen)
        begin
            // start a long hold-off so the result queue fills and input stalls
            hold_seen    = hold_req_cnt;
            rx_hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(rx_gaps && ($urandom_range(99) < 29));
    end

    // Offer one byte, idling first at random, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps)
            while ($urandom_range(99) < 29)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
        phase_bytes++;
    endtask

    // Encoded form of a code point, lead byte in the low bits
    function automatic logic [31:0] utf8_seq(int n, logic [20:0] cp);
        case (n)
            2:       return {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
            3:       return {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
            default: return {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                             5'b11110, cp[20:18]};
        endcase
    endfunction

    // Send the first count bytes of an encoded sequence
    task automatic send_seq(input logic [31:0] seq, input int count);
        for (int i = 0; i < count; i++)
            send_byte(seq[8*i +: 8]);
    endtask

    // One random string ended by a zero byte: mostly well formed, some broken, some noise
    task automatic send_string();
        int          chars;
        int          pick;
        int          n;
        logic [20:0] cp;
        chars = $urandom_range(0, 8);
        if ($urandom_range(99) < 5)
            repeat (chars + 1) send_byte(8'($urandom_range(1, 255)));
        else
            for (int c = 0; c < chars; c++)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    send_byte(8'($urandom_range(1, 127)));
                else if (pick < 48)
                    send_seq(utf8_seq(2, 21'($urandom_range(0, 'h7FF))), 2);
                else if (pick < 70)
                begin
                    case ($urandom_range(3))
                        0, 1: cp = 21'($urandom_range(0, 'hFFFF));
                        2:    cp = 21'($urandom_range('h2660, 'h2780));
                        default:
                            case ($urandom_range(4))
                                0:       cp = {5'd0, CHECK_HEAVY_IN};
                                1:       cp = {5'd0, SYM_LO};
                                2:       cp = {5'd0, SYM_HI};
                                3:       cp = {5'd0, SYM_LO - 16'd1};
                                default: cp = {5'd0, SYM_HI + 16'd1};
                            endcase
                    endcase
                    send_seq(utf8_seq(3, cp), 3);
                end
                else if (pick < 94)
                begin
                    case ($urandom_range(4))
                        0: cp = 21'($urandom_range(0, 'h1FFFFF));
                        1: cp = 21'($urandom_range('h10000, 'h10FFFF));
                        2: cp = 21'($urandom_range('h1F2F0, 'h1F660));
                        3:
                            case ($urandom_range(6))
                                0:       cp = BALLOON;
                                1:       cp = RED_CIRCLE;
                                2:       cp = BLUE_CIRCLE;
                                3:       cp = EMOJI_LO;
                                4:       cp = EMOJI_HI;
                                5:       cp = PICTO_LO;
                                default: cp = PICTO_LO - 21'd1;
                            endcase
                        default: cp = 21'($urandom_range(0, 'hFFFF));  // overlong
                    endcase
                    send_seq(utf8_seq(4, cp), 4);
                end
                else if (pick < 96)
                begin
                    // bad lead byte: a stray continuation or an out-of-range lead
                    if ($urandom_range(1))
                        send_byte(8'($urandom_range('h80, 'hBF)));
                    else
                        send_byte(8'($urandom_range('hF8, 'hFF)));
                end
                else
                begin
                    n  = $urandom_range(2, 4);
                    cp = 21'($urandom_range(0, 'h1FFFFF));
                    send_seq(utf8_seq(n, cp), $urandom_range(1, n - 1));
                    if (pick < 98)
                    begin
                        // bad continuation byte; the rest of the string is ignored
                        if ($urandom_range(1))
                            send_byte(8'($urandom_range(1, 'h7F)));
                        else
                            send_byte(8'($urandom_range('hC0, 'hFF)));
                    end
                    else
                        break;  // truncated: terminator follows at once
                end
            end
        send_byte(8'h00);
    endtask

    // Stop offering and wait until every expected unit has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= OS_ADDR;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.os_level = d[1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(output logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= OS_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        d = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] rd;
        logic        hold_asked;
        logic        pause_done;
        sb         = new();
        hold_asked = 1'b0;
        pause_done = 1'b0;

        // Hold reset, then release it for good
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_read(rd);
        if (rd !== {30'd0, u8u16dec_pkg::OS_LEVEL_RESET})
            sb.report($sformatf("os_level after reset reads %h", rd));

        // Directed strings at the reset setting
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // Config only moves while the decoder is idle
            drain();
            apb_write({30'd0, phase_os[ph]});
            apb_read(rd);
            if (rd !== {30'd0, phase_os[ph]})
                sb.report($sformatf("os_level reads %h after writing %0d", rd, phase_os[ph]));

            // Last phase runs both sides flat out
            tx_gaps = (ph != PHASES - 1);
            rx_gaps <= (ph != PHASES - 1);
            phase_bytes = 0;

            while (phase_bytes < PHASE_BYTES)
            begin
                if (ph == 1 && !hold_asked && phase_bytes >= 60)
                begin
                    hold_req_cnt <= hold_req_cnt + 1;
                    hold_asked = 1'b1;
                end
                if (ph == 2 && !pause_done && phase_bytes >= 150)
                begin
                    // sender pauses mid-stream until the output side is empty
                    drain();
                    pause_done = 1'b1;
                end
                send_string();
            end
        end

        drain();

        $display("Decoded %0d bytes in %0d strings, %0d of them flagged bad, over os_level 0 to 3",
                 bytes_sent, sb.strings_done, sb.strings_bad);
        $display("Checked %0d code units with a %0d-cycle receiver hold-off and a drain pause",
                 sb.units_seen, HOLD_CYCLES);
        if (sb.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/u8u16dec_pkg.sv
rtl/core/u8u16dec_core.sv
rtl/core/u8u16dec_outq.sv
rtl/core/utf8_to_utf16_decoder.sv
rtl/core/u8u16dec_checker.sv
tb/sv/utf8_to_utf16_decoder_tb.sv
